/* rtl/spq_pkg.sv */
// Package for the stable priority queue: field widths, status and mode codes,
// and the control struct passed from the top level to each cell.
// Has no dependencies.
package spq_pkg;

	localparam int DATA_W      = 32;
	localparam int PRIO_W      = 8;
	localparam int OCC_W       = 5;
	localparam int DEPTH_DEF   = 16;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	localparam logic [1:0] ST_ENQ   = 2'd0;
	localparam logic [1:0] ST_DEQ   = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic enq;
		logic deq;
		logic occupied;
		logic left_displace;
	} cell_ctl_t;

endpackage

/* rtl/spq_cell.sv */
// One storage cell of the sorted queue chain: holds a data word and priority.
// Depends on spq_pkg.
module spq_cell (
	input  logic                             clk,
	input  spq_pkg::cell_ctl_t               ctl,
	input  logic signed [spq_pkg::DATA_W-1:0] new_data,
	input  logic        [spq_pkg::PRIO_W-1:0] new_prio,
	input  logic signed [spq_pkg::DATA_W-1:0] left_data,
	input  logic        [spq_pkg::PRIO_W-1:0] left_prio,
	input  logic signed [spq_pkg::DATA_W-1:0] right_data,
	input  logic        [spq_pkg::PRIO_W-1:0] right_prio,
	output logic signed [spq_pkg::DATA_W-1:0] data,
	output logic        [spq_pkg::PRIO_W-1:0] prio,
	output logic                             displace
);
	import spq_pkg::*;

	logic signed [DATA_W-1:0] data_q;
	logic        [PRIO_W-1:0] prio_q;

	// A new entry goes before this cell when the cell is empty or holds a
	// strictly greater priority, which keeps equal priorities in arrival order.
	assign displace = !ctl.occupied || (prio_q > new_prio);
	assign data     = data_q;
	assign prio     = prio_q;

	always_ff @(posedge clk) begin
		if (ctl.enq) begin
			if (displace) begin
				if (ctl.left_displace) begin
					data_q <= left_data;
					prio_q <= left_prio;
				end else begin
					data_q <= new_data;
					prio_q <= new_prio;
				end
			end
		end else if (ctl.deq) begin
			data_q <= right_data;
			prio_q <= right_prio;
		end
	end

endmodule

/* rtl/stable_priority_queue_unit.sv */
// Top level of the stable priority queue: a chain of sorted cells, the entry
// count and the result register. Depends on spq_pkg and spq_cell.
//
// Channel  Dir  tdata                                    tuser
// s_       in   [31:0] item_data, [39:32] item_priority  [0] mode
// m_       out  [31:0] out_data, [39:32] out_priority,   [1:0] status
//               [44:40] occupancy, [47:45] zero
//
// One transfer in per cycle unless the input stalls; every cell compares
// against the new priority and shifts in the same cycle, so the result is in
// the output register in the cycle after the input transfer. The input stalls
// only while a result waits in that register and m_tready is low. Reset
// empties the queue and the output register; cell contents are not cleared.
module stable_priority_queue_unit #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // item_data, item_priority
	input  logic [0:0]  s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // out_data, out_priority, occupancy
	output logic [1:0]  m_tuser   // status
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic                     in_xfer;
	logic                     mode;
	logic signed [DATA_W-1:0] item_data;
	logic        [PRIO_W-1:0] item_priority;
	logic        [CW-1:0]     count_q;
	logic                     full;
	logic                     empty;
	logic                     do_enq;
	logic                     do_deq;
	logic        [CW-1:0]     count_next;

	logic signed [DATA_W-1:0] cell_data [DEPTH];
	logic        [PRIO_W-1:0] cell_prio [DEPTH];
	logic                     cell_disp [DEPTH];

	logic                     out_valid_q;
	logic        [1:0]        status_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic        [PRIO_W-1:0] out_prio_q;
	logic        [OCC_W-1:0]  occ_q;

	assign s_tready      = !out_valid_q || m_tready;
	assign in_xfer       = s_tvalid && s_tready;
	assign mode          = s_tuser[0];
	assign item_data     = s_tdata[31:0];
	assign item_priority = s_tdata[39:32];

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign do_enq = in_xfer && (mode == MODE_ENQ) && !full;
	assign do_deq = in_xfer && (mode == MODE_DEQ) && !empty;

	always_comb begin
		count_next = count_q;
		if (do_enq) begin
			count_next = count_q + CW'(1);
		end else if (do_deq) begin
			count_next = count_q - CW'(1);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t                ctl;
		logic signed [DATA_W-1:0] l_data;
		logic        [PRIO_W-1:0] l_prio;
		logic signed [DATA_W-1:0] r_data;
		logic        [PRIO_W-1:0] r_prio;

		if (i == 0) begin : g_head
			assign ctl.left_displace = 1'b0;
			assign l_data            = item_data;
			assign l_prio            = item_priority;
		end else begin : g_body
			assign ctl.left_displace = cell_disp[i-1];
			assign l_data            = cell_data[i-1];
			assign l_prio            = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_data = cell_data[i];
			assign r_prio = cell_prio[i];
		end else begin : g_mid
			assign r_data = cell_data[i+1];
			assign r_prio = cell_prio[i+1];
		end

		assign ctl.enq      = do_enq;
		assign ctl.deq      = do_deq;
		assign ctl.occupied = (count_q > CW'(i));

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_data   (item_data),
			.new_prio   (item_priority),
			.left_data  (l_data),
			.left_prio  (l_prio),
			.right_data (r_data),
			.right_prio (r_prio),
			.data       (cell_data[i]),
			.prio       (cell_prio[i]),
			.displace   (cell_disp[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (in_xfer) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			occ_q      <= OCC_W'(count_next);
			out_data_q <= '0;
			out_prio_q <= '0;
			if (mode == MODE_ENQ) begin
				status_q <= full ? ST_FULL : ST_ENQ;
			end else if (empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q   <= ST_DEQ;
				out_data_q <= cell_data[0];
				out_prio_q <= cell_prio[0];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {3'b000, occ_q, out_prio_q, out_data_q};

	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	a_enq_grows : assert property (@(posedge clk) disable iff (!arst_n)
		do_enq |=> count_q == $past(count_q) + CW'(1))
		else $error("enqueue did not add an entry");

	a_empty_status : assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && mode == MODE_DEQ && empty |=> m_tvalid && m_tuser == ST_EMPTY)
		else $error("dequeue on empty queue not reported");

	a_head_sorted : assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(2) |-> cell_prio[0] <= cell_prio[1])
		else $error("head entries out of order");

endmodule

/* tb/stable_priority_queue_unit_checker.sv */
`timescale 1ns / 100ps
// Checker for stable_priority_queue_unit: watches both stream channels, keeps its own sorted
// copy of the queue to predict each result and compares every output transfer against it.
// Depends on spq_pkg.
module stable_priority_queue_unit_checker #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,  // item_data, item_priority
	input  logic [0:0]  s_tuser,  // mode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,  // out_data, out_priority, occupancy
	input  logic [1:0]  m_tuser,  // status
	output int          fail_count,
	output int          pending
);
	import spq_pkg::*;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] data;
		logic [PRIO_W-1:0] prio;
		logic [OCC_W-1:0]  occ;
	} queue_result_t;

	logic [DATA_W-1:0] held_data [DEPTH];
	logic [PRIO_W-1:0] held_prio [DEPTH];
	int                held_count;
	queue_result_t     expected_results [$];

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		$display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic queue_result_t apply_queue_op(input logic mode,
			input logic [DATA_W-1:0] data, input logic [PRIO_W-1:0] prio);
		queue_result_t r;
		int pos;
		r = '0;
		if (mode == MODE_ENQ) begin
			if (held_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_count && held_prio[pos] <= prio)
					pos++;
				for (int i = held_count; i > pos; i--) begin
					held_data[i] = held_data[i-1];
					held_prio[i] = held_prio[i-1];
				end
				held_data[pos] = data;
				held_prio[pos] = prio;
				held_count++;
				r.status = ST_ENQ;
			end
		end else if (held_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.status = ST_DEQ;
			r.data = held_data[0];
			r.prio = held_prio[0];
			for (int i = 1; i < held_count; i++) begin
				held_data[i-1] = held_data[i];
				held_prio[i-1] = held_prio[i];
			end
			held_count--;
		end
		r.occ = held_count[OCC_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		queue_result_t want;
		if (!arst_n) begin
			held_count = 0;
			expected_results.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, '0);
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.status)
						report_mismatch("status", 48'(m_tuser), 48'(want.status));
					if (m_tdata[31:0] !== want.data)
						report_mismatch("out_data", 48'(m_tdata[31:0]), 48'(want.data));
					if (m_tdata[39:32] !== want.prio)
						report_mismatch("out_priority", 48'(m_tdata[39:32]),
								48'(want.prio));
					if (m_tdata[44:40] !== want.occ)
						report_mismatch("occupancy", 48'(m_tdata[44:40]), 48'(want.occ));
					if (m_tdata[47:45] !== 3'b000)
						report_mismatch("tdata padding", 48'(m_tdata[47:45]), '0);
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_queue_op(s_tuser[0], s_tdata[31:0],
						s_tdata[39:32]));
			pending = expected_results.size();
		end
	end

endmodule

/* tb/stable_priority_queue_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench top for stable_priority_queue_unit: drives directed and random enqueue and dequeue
// transfers with random idling on both channels and gives the verdict.
// Depends on spq_pkg, stable_priority_queue_unit and stable_priority_queue_unit_checker.
module stable_priority_queue_unit_tb;
	import spq_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int RAND_ITEMS  = 600;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;  // item_data, item_priority
	logic [0:0]  s_tuser  = '0;  // mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // out_data, out_priority, occupancy
	logic [1:0]  m_tuser;        // status
	logic        calm     = 1'b0;
	int          fail_count;
	int          pending;
	int          cycles   = 0;

	stable_priority_queue_unit #(.DEPTH(DEPTH)) dut (.*);

	stable_priority_queue_unit_checker #(.DEPTH(DEPTH)) u_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n)
			m_tready <= calm || ($urandom_range(99) >= 15);
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_item(input logic mode, input logic [DATA_W-1:0] data,
			input logic [PRIO_W-1:0] prio);
		while (!calm && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {prio, data};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		int issued;
		int bias;
		int run_len;
		int enq_pct;
		logic mode;
		logic [PRIO_W-1:0] prio;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Dequeue from an empty queue, then fill it with extremes and ties.
		send_item(MODE_DEQ, 32'hFFFF_FFFF, 8'hFF);
		send_item(MODE_ENQ, 32'h8000_0000, 8'd255);
		send_item(MODE_ENQ, 32'h7FFF_FFFF, 8'd0);
		send_item(MODE_ENQ, 32'h0000_0000, 8'd128);
		send_item(MODE_ENQ, 32'hFFFF_FFFF, 8'd0);
		for (int i = 0; i < DEPTH - 4; i++)
			send_item(MODE_ENQ, 32'h1000_0000 + i, 8'((i % 3) * 64));
		// The queue is full now, so this one is rejected.
		send_item(MODE_ENQ, 32'hDEAD_BEEF, 8'd0);
		for (int i = 0; i < 5; i++)
			send_item(MODE_DEQ, '0, '0);
		wait_drained();

		issued = 0;
		while (issued < RAND_ITEMS) begin
			bias = $urandom_range(2);
			run_len = $urandom_range(10, 50);
			case (bias)
				0: enq_pct = 85;
				1: enq_pct = 20;
				default: enq_pct = 50;
			endcase
			for (int k = 0; k < run_len && issued < RAND_ITEMS; k++) begin
				calm <= (issued >= 250 && issued < 350);
				mode = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
				prio = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
				send_item(mode, $urandom, prio);
				issued++;
				if (issued == 420)
					wait_drained();
			end
		end
		calm <= 1'b0;
		wait_drained();
		repeat (5) @(posedge clk);

		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue_unit.sv
tb/stable_priority_queue_unit_checker.sv
tb/stable_priority_queue_unit_tb.sv
